// ===== design/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg
// Shared types and fixed field widths for the trial division prime generator.
// ----------------------------------------------------------------------------
package ptd_pkg;

	localparam int CAND_W  = 24;
	localparam int LIMIT_W = 24;
	localparam int COUNT_W = 21;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	// control tag that travels with each divisor along the cell row
	typedef struct packed {
		logic valid;
		logic last;   // table exhausted: no divisor, candidate is prime
		logic stop;   // p*p > candidate (or end of table): candidate is prime
	} ptd_tag_t;

endpackage

// ===== design/ptd_div_cell.sv =====
// ----------------------------------------------------------------------------
// ptd_div_cell
// One restoring-division step: shifts in one candidate bit and subtracts the
// divisor when it fits, then hands divisor and partial remainder onward.
// ----------------------------------------------------------------------------
module ptd_div_cell import ptd_pkg::*; #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         kill,
	input  ptd_tag_t     tag_in,
	input  logic [W-1:0] p_in,
	input  logic [W-1:0] rem_in,
	input  logic         cbit,
	output ptd_tag_t     tag_q,
	output logic [W-1:0] p_q,
	output logic [W-1:0] rem_q
);

	logic [W:0]   sh;
	logic [W:0]   diff;
	logic [W-1:0] rem_nxt;

	always_comb begin
		sh   = {rem_in, cbit};
		diff = sh - {1'b0, p_in};
		if (sh >= {1'b0, p_in}) begin
			rem_nxt = diff[W-1:0];
		end else begin
			rem_nxt = sh[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (kill) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		p_q   <= p_in;
		rem_q <= rem_nxt;
	end

endmodule

// ===== design/ptd_div_chain.sv =====
// ----------------------------------------------------------------------------
// ptd_div_chain
// Row of W division cells, MSB of the candidate first; one divisor enters per
// cycle and its remainder leaves from the last cell.
// ----------------------------------------------------------------------------
module ptd_div_chain import ptd_pkg::*; #(
	parameter int W = 24
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         kill,
	input  logic [W-1:0] cand,
	input  ptd_tag_t     tag_in,
	input  logic [W-1:0] p_in,
	output ptd_tag_t     tag_out,
	output logic [W-1:0] rem_out
);

	ptd_tag_t     tag_c [0:W];
	logic [W-1:0] p_c   [0:W];
	logic [W-1:0] rem_c [0:W];

	assign tag_c[0] = tag_in;
	assign p_c[0]   = p_in;
	assign rem_c[0] = '0;

	for (genvar i = 0; i < W; i++) begin : g_cell
		ptd_div_cell #(.W(W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.kill   (kill),
			.tag_in (tag_c[i]),
			.p_in   (p_c[i]),
			.rem_in (rem_c[i]),
			.cbit   (cand[W-1-i]),
			.tag_q  (tag_c[i+1]),
			.p_q    (p_c[i+1]),
			.rem_q  (rem_c[i+1])
		);
	end

	assign tag_out = tag_c[W];
	assign rem_out = rem_c[W];

endmodule

// ===== design/prime_trial_division_generator_unit.sv =====
// ----------------------------------------------------------------------------
// prime_trial_division_generator_unit
// Prime generator by trial division against a table of the primes found.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         mode, limit
//  result    strobe (no stall)    candidate, is_prime, prime_count, done_res
//
// Start requests and steps that report done give their result in the cycle after
// acceptance. A tested step sends entries down the VALUE_WIDTH-deep division row,
// one per cycle: table primes up to the first with p*p > candidate or the first
// divisor, plus an end marker when the table runs out. Its result follows when
// the deciding entry leaves the row, and busy is high meanwhile. The prime table
// needs no clearing after reset. The result side cannot stall.
module prime_trial_division_generator_unit import ptd_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               mode,
	input  logic [LIMIT_W-1:0] limit,
	output logic               strobe,
	output logic [CAND_W-1:0]  candidate,
	output logic               is_prime,
	output logic [COUNT_W-1:0] prime_count,
	output logic               done_res
);

	localparam int W  = VALUE_WIDTH;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EVAL = 1'b1;

	logic              state_q;
	logic [W-1:0]      next_q;
	logic [W-1:0]      limit_q;
	logic [CW-1:0]     stored_q;
	logic [COUNT_W-1:0] found_q;
	logic [W-1:0]      cand_q;
	logic [CW-1:0]     idx_q;
	logic              end_sent_q;

	ptd_tag_t          tag_s1;
	ptd_tag_t          tag_s2;
	logic [W-1:0]      p_s1;
	logic [W-1:0]      p_s2;
	logic [2*W-1:0]    sq_s2;

	logic [W-1:0]      mem [0:TABLE_DEPTH-1];

	logic              accept;
	logic [W-1:0]      lim_v;
	logic              start_prime;
	logic              step_done;
	logic              issue_en;
	logic              have_entry;
	logic              decide;
	logic              found_prime;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [W-1:0]      wr_data;
	logic              rd_en;
	logic [W:0]        cand_sum;
	logic [W-1:0]      next_sat;
	logic [COUNT_W-1:0] found_inc;
	ptd_tag_t          tag_in;
	ptd_tag_t          tail_tag;
	logic [W-1:0]      tail_rem;

	assign busy   = (state_q == ST_EVAL);
	assign accept = start && !busy;
	assign lim_v  = W'(limit);

	assign start_prime = (lim_v > W'(2));
	assign step_done   = (next_q >= limit_q);

	assign have_entry = (idx_q < stored_q);
	assign decide     = tail_tag.valid && (tail_tag.stop || (tail_rem == '0));
	assign found_prime = tail_tag.stop;
	assign issue_en   = (state_q == ST_EVAL) && !end_sent_q && !decide;
	assign rd_en      = issue_en && have_entry;

	assign cand_sum  = {1'b0, cand_q} + (W+1)'(2);
	assign next_sat  = cand_sum[W] ? '1 : cand_sum[W-1:0];
	assign found_inc = (found_q != COUNT_MAX) ? found_q + COUNT_W'(1) : found_q;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = stored_q[AW-1:0];
		wr_data = cand_q;
		if (accept && (mode == MODE_START)) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_data = W'(2);
		end else if (decide && found_prime && (stored_q < DEPTH_C)) begin
			wr_en = 1'b1;
		end
	end

	// table: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			p_s1 <= mem[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		p_s2  <= p_s1;
		sq_s2 <= {{W{1'b0}}, p_s1} * {{W{1'b0}}, p_s1};
	end

	always_comb begin
		tag_in.valid = tag_s2.valid;
		tag_in.last  = tag_s2.last;
		tag_in.stop  = tag_s2.last || (p_s2 == '0) || (sq_s2 > {{W{1'b0}}, cand_q});
	end

	ptd_div_chain #(.W(W)) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.kill    (decide),
		.cand    (cand_q),
		.tag_in  (tag_in),
		.p_in    (p_s2),
		.tag_out (tail_tag),
		.rem_out (tail_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			next_q     <= W'(3);
			limit_q    <= '0;
			stored_q   <= '0;
			found_q    <= '0;
			idx_q      <= '0;
			end_sent_q <= 1'b0;
			tag_s1     <= '0;
			tag_s2     <= '0;
			strobe     <= 1'b0;
		end else begin
			strobe <= 1'b0;
			if (decide) begin
				tag_s1 <= '0;
				tag_s2 <= '0;
			end else begin
				tag_s1.valid <= issue_en;
				tag_s1.last  <= !have_entry;
				tag_s1.stop  <= 1'b0;
				tag_s2       <= tag_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode == MODE_START) begin
							limit_q  <= lim_v;
							stored_q <= CW'(1);
							found_q  <= start_prime ? COUNT_W'(1) : '0;
							next_q   <= W'(3);
							strobe   <= 1'b1;
						end else if (step_done) begin
							strobe <= 1'b1;
						end else begin
							state_q    <= ST_EVAL;
							idx_q      <= '0;
							end_sent_q <= 1'b0;
						end
					end
				end
				ST_EVAL: begin
					if (decide) begin
						state_q <= ST_IDLE;
						strobe  <= 1'b1;
						next_q  <= next_sat;
						if (found_prime) begin
							found_q <= found_inc;
							if (stored_q < DEPTH_C) begin
								stored_q <= stored_q + CW'(1);
							end
						end
					end else if (issue_en) begin
						if (have_entry) begin
							idx_q <= idx_q + CW'(1);
						end else begin
							end_sent_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q <= next_q;
		end
		if (accept && (mode == MODE_START)) begin
			candidate   <= CAND_W'(2);
			is_prime    <= start_prime;
			prime_count <= start_prime ? COUNT_W'(1) : '0;
			done_res    <= !start_prime;
		end else if (accept && step_done) begin
			candidate   <= CAND_W'(next_q);
			is_prime    <= 1'b0;
			prime_count <= found_q;
			done_res    <= 1'b1;
		end else if (decide) begin
			candidate   <= CAND_W'(cand_q);
			is_prime    <= found_prime;
			prime_count <= found_prime ? found_inc : found_q;
			done_res    <= 1'b0;
		end
	end

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("result strobe while evaluating");

	a_prime_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_prime) |-> !done_res)
		else $error("prime reported together with done");

	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= DEPTH_C)
		else $error("stored count beyond table depth");

	a_tail_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		tail_tag.valid |-> busy)
		else $error("divisor in cell row outside evaluation");

	a_start_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (mode == MODE_START)) |=> (strobe && (candidate == CAND_W'(2))))
		else $error("start request did not report 2");

endmodule
